// ----- design/shape_pair_collision_2d_assert.svh -----
// ----------------------------------------------------------------------------
// shape_pair_collision_2d assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef SHAPE_PAIR_COLLISION_2D_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_2D_ASSERT_SVH

// plain property that must hold at every edge out of reset
`define SPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define SPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/spcol_pkg.sv -----
// ----------------------------------------------------------------------------
// spcol_pkg
// shared widths, shape and pair codes and word types of the collision block
// ----------------------------------------------------------------------------
package spcol_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int KIND_WIDTH  = 2;
    localparam int OQ_DEPTH    = 2;

    // shape kinds
    localparam logic [KIND_WIDTH-1:0] KIND_POINT   = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_RECT    = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_CIRCLE  = 2'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_UNKNOWN = 2'd3;

    // pair class after sorting so that the first kind is the lower one
    typedef enum logic [2:0] {
        PAIR_NONE = 3'd0,
        PAIR_PP   = 3'd1,
        PAIR_PR   = 3'd2,
        PAIR_PC   = 3'd3,
        PAIR_RR   = 3'd4,
        PAIR_RC   = 3'd5,
        PAIR_CC   = 3'd6
    } t_pair;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]         a_kind;
        logic signed [COORD_WIDTH-1:0] a_pos_x;
        logic signed [COORD_WIDTH-1:0] a_pos_y;
        logic [SIZE_WIDTH-1:0]         a_width;
        logic [SIZE_WIDTH-1:0]         a_height;
        logic [KIND_WIDTH-1:0]         b_kind;
        logic signed [COORD_WIDTH-1:0] b_pos_x;
        logic signed [COORD_WIDTH-1:0] b_pos_y;
        logic [SIZE_WIDTH-1:0]         b_width;
        logic [SIZE_WIDTH-1:0]         b_height;
    } t_in_word;

    typedef struct packed {
        logic hit;
        logic zero_size_warning;
    } t_out_word;

    // geometry front end to product back end
    typedef struct packed {
        t_pair                 pair;
        logic                  done;      // answer known without the products
        logic                  done_hit;
        logic                  warn;
        logic [SIZE_WIDTH-1:0] mx;        // operands to square
        logic [SIZE_WIDTH-1:0] my;
        logic [SIZE_WIDTH-1:0] pw;
        logic [SIZE_WIDTH-1:0] ph;
        logic [SIZE_WIDTH-1:0] qw;
        logic [SIZE_WIDTH-1:0] qh;
    } t_geom;

endpackage

// ----- design/spcol_geom.sv -----
// ----------------------------------------------------------------------------
// spcol_geom
// two stages: sort the shapes by kind and take centre differences, then
// absolute distances, box tests and the operands for the round tests
// ----------------------------------------------------------------------------
module spcol_geom import spcol_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_word i_word,
    output logic     o_valid,
    output t_geom    o_geom
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = SIZE_WIDTH;

    // stage 1
    logic                  swap;
    logic [KIND_WIDTH-1:0] p_kind;
    logic [KIND_WIDTH-1:0] q_kind;
    logic signed [CW-1:0]  p_x, p_y, q_x, q_y;
    logic [SW-1:0]         p_w, p_h, q_w, q_h;
    t_pair                 n_s1_pair;
    logic signed [CW:0]    n_s1_dfx, n_s1_dfy;

    logic                  r_s1_v;
    t_pair                 r_s1_pair;
    logic signed [CW:0]    r_s1_dfx, r_s1_dfy;
    logic [SW-1:0]         r_s1_pw, r_s1_ph, r_s1_qw, r_s1_qh;

    // stage 2
    logic [CW:0]   neg_x, neg_y;
    logic [CW-1:0] adx, ady;
    logic [CW:0]   dx2, dy2;
    logic [CW-1:0] sum_w, sum_h;
    logic [CW:0]   rc_x, rc_y;
    logic          pt_eq, pr_in, rr_in, rc_out, rc_cross, pc_far, cc_far;
    logic          p_zero, q_zero;
    t_geom         n_s2_geom;

    logic          r_s2_v;
    t_geom         r_s2_geom;

    always_comb begin
        swap   = i_word.a_kind > i_word.b_kind;
        p_kind = swap ? i_word.b_kind   : i_word.a_kind;
        q_kind = swap ? i_word.a_kind   : i_word.b_kind;
        p_x    = swap ? i_word.b_pos_x  : i_word.a_pos_x;
        p_y    = swap ? i_word.b_pos_y  : i_word.a_pos_y;
        q_x    = swap ? i_word.a_pos_x  : i_word.b_pos_x;
        q_y    = swap ? i_word.a_pos_y  : i_word.b_pos_y;
        p_w    = swap ? i_word.b_width  : i_word.a_width;
        p_h    = swap ? i_word.b_height : i_word.a_height;
        q_w    = swap ? i_word.a_width  : i_word.b_width;
        q_h    = swap ? i_word.a_height : i_word.b_height;

        n_s1_dfx = $signed({p_x[CW-1], p_x}) - $signed({q_x[CW-1], q_x});
        n_s1_dfy = $signed({p_y[CW-1], p_y}) - $signed({q_y[CW-1], q_y});

        // the sort leaves an unknown kind on the second side
        priority if (q_kind == KIND_UNKNOWN) begin
            n_s1_pair = PAIR_NONE;
        end else if (p_kind == KIND_POINT && q_kind == KIND_POINT) begin
            n_s1_pair = PAIR_PP;
        end else if (p_kind == KIND_POINT && q_kind == KIND_RECT) begin
            n_s1_pair = PAIR_PR;
        end else if (p_kind == KIND_POINT) begin
            n_s1_pair = PAIR_PC;
        end else if (p_kind == KIND_RECT && q_kind == KIND_RECT) begin
            n_s1_pair = PAIR_RR;
        end else if (p_kind == KIND_RECT) begin
            n_s1_pair = PAIR_RC;
        end else begin
            n_s1_pair = PAIR_CC;
        end
    end

    always_comb begin
        neg_x = -r_s1_dfx;
        neg_y = -r_s1_dfy;
        adx   = r_s1_dfx[CW] ? neg_x[CW-1:0] : r_s1_dfx[CW-1:0];
        ady   = r_s1_dfy[CW] ? neg_y[CW-1:0] : r_s1_dfy[CW-1:0];
        dx2   = {adx, 1'b0};
        dy2   = {ady, 1'b0};
        sum_w = {1'b0, r_s1_pw} + {1'b0, r_s1_qw};
        sum_h = {1'b0, r_s1_ph} + {1'b0, r_s1_qh};
        rc_x  = dx2 - {2'b00, r_s1_pw};
        rc_y  = dy2 - {2'b00, r_s1_ph};

        pt_eq    = (adx == '0) && (ady == '0);
        pr_in    = (dx2 <= {2'b00, r_s1_qw}) && (dy2 <= {2'b00, r_s1_qh});
        rr_in    = (dx2 <= {1'b0, sum_w}) && (dy2 <= {1'b0, sum_h});
        rc_out   = !rr_in;
        rc_cross = (dx2 <= {2'b00, r_s1_pw}) || (dy2 <= {2'b00, r_s1_ph});
        // past any size: the square alone already exceeds the area
        pc_far   = (dx2[CW:SW] != '0) || (dy2[CW:SW] != '0);
        cc_far   = adx[CW-1] || ady[CW-1];
        p_zero   = (r_s1_pw == '0) || (r_s1_ph == '0);
        q_zero   = (r_s1_qw == '0) || (r_s1_qh == '0);

        n_s2_geom.pair     = r_s1_pair;
        n_s2_geom.done     = 1'b1;
        n_s2_geom.done_hit = 1'b0;
        n_s2_geom.warn     = 1'b0;
        n_s2_geom.mx       = dx2[SW-1:0];
        n_s2_geom.my       = dy2[SW-1:0];
        n_s2_geom.pw       = r_s1_pw;
        n_s2_geom.ph       = r_s1_ph;
        n_s2_geom.qw       = r_s1_qw;
        n_s2_geom.qh       = r_s1_qh;

        unique case (r_s1_pair)
            PAIR_PP: n_s2_geom.done_hit = pt_eq;
            PAIR_PR: n_s2_geom.done_hit = pr_in;
            PAIR_RR: n_s2_geom.done_hit = rr_in;
            PAIR_PC: begin
                n_s2_geom.warn = q_zero;
                n_s2_geom.done = q_zero || pc_far;
            end
            PAIR_RC: begin
                n_s2_geom.mx = rc_x[SW-1:0];
                n_s2_geom.my = rc_y[SW-1:0];
                priority if (rc_out) begin
                    n_s2_geom.done_hit = 1'b0;
                end else if (rc_cross) begin
                    n_s2_geom.done_hit = 1'b1;
                end else begin
                    n_s2_geom.done = 1'b0;
                end
            end
            PAIR_CC: begin
                n_s2_geom.mx   = adx[SW-1:0];
                n_s2_geom.my   = ady[SW-1:0];
                n_s2_geom.warn = p_zero || q_zero;
                n_s2_geom.done = p_zero || q_zero || cc_far;
            end
            default: n_s2_geom.done = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pair <= n_s1_pair;
            r_s1_dfx  <= n_s1_dfx;
            r_s1_dfy  <= n_s1_dfy;
            r_s1_pw   <= p_w;
            r_s1_ph   <= p_h;
            r_s1_qw   <= q_w;
            r_s1_qh   <= q_h;
            r_s2_geom <= n_s2_geom;
        end
    end

    assign o_valid = r_s2_v;
    assign o_geom  = r_s2_geom;

endmodule

// ----- design/spcol_prod.sv -----
// ----------------------------------------------------------------------------
// spcol_prod
// three stages: squares and areas, round tests and split partial products,
// product assembly; the ellipse compare and result select follow combinationally
// ----------------------------------------------------------------------------
module spcol_prod import spcol_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_geom     i_geom,
    output logic      o_valid,
    output t_out_word o_word
);

    localparam int SW = SIZE_WIDTH;
    localparam int PW = 2 * SIZE_WIDTH;
    localparam int QW = 4 * SIZE_WIDTH;

    // stage 3
    logic          r_s3_v;
    t_pair         r_s3_pair;
    logic          r_s3_done, r_s3_done_hit, r_s3_warn;
    logic [PW-1:0] r_s3_sqx, r_s3_sqy, r_s3_ww, r_s3_hh, r_s3_aq;

    // stage 4
    logic [PW:0]   csum;
    logic          n_s4_circ_hit, n_s4_cc_near;
    logic [PW-1:0] a_op [3];
    logic [PW-1:0] b_op [3];
    logic [PW-1:0] n_s4_pp [3][4];

    logic          r_s4_v;
    t_pair         r_s4_pair;
    logic          r_s4_done, r_s4_done_hit, r_s4_warn;
    logic          r_s4_circ_hit, r_s4_cc_near;
    logic [PW-1:0] r_s4_pp [3][4];

    // stage 5
    logic [QW-1:0] n_s5_prod [3];
    logic          r_s5_v;
    t_pair         r_s5_pair;
    logic          r_s5_done, r_s5_done_hit, r_s5_warn;
    logic          r_s5_circ_hit, r_s5_cc_near;
    logic [QW-1:0] r_s5_prod [3];

    logic [QW:0]   lhs;
    logic          cc_hit;

    always_comb begin
        csum          = {1'b0, r_s3_sqx} + {1'b0, r_s3_sqy};
        // rectangle corner is inclusive, point in circle is strict
        n_s4_circ_hit = (r_s3_pair == PAIR_RC) ? (csum <= {1'b0, r_s3_aq})
                                               : (csum <  {1'b0, r_s3_aq});
        n_s4_cc_near  = (r_s3_sqx < r_s3_ww) && (r_s3_sqy < r_s3_hh);

        // dx^2*hh, dy^2*ww, ww*hh
        a_op[0] = r_s3_sqx;  b_op[0] = r_s3_hh;
        a_op[1] = r_s3_sqy;  b_op[1] = r_s3_ww;
        a_op[2] = r_s3_ww;   b_op[2] = r_s3_hh;
        for (int k = 0; k < 3; k++) begin
            n_s4_pp[k][0] = PW'(a_op[k][SW-1:0]) * PW'(b_op[k][SW-1:0]);
            n_s4_pp[k][1] = PW'(a_op[k][SW-1:0]) * PW'(b_op[k][PW-1:SW]);
            n_s4_pp[k][2] = PW'(a_op[k][PW-1:SW]) * PW'(b_op[k][SW-1:0]);
            n_s4_pp[k][3] = PW'(a_op[k][PW-1:SW]) * PW'(b_op[k][PW-1:SW]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s5_prod[k] = (QW'(r_s4_pp[k][3]) << PW)
                         + ((QW'(r_s4_pp[k][1]) + QW'(r_s4_pp[k][2])) << SW)
                         + QW'(r_s4_pp[k][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (i_en) begin
            r_s3_v <= i_valid;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_pair     <= i_geom.pair;
            r_s3_done     <= i_geom.done;
            r_s3_done_hit <= i_geom.done_hit;
            r_s3_warn     <= i_geom.warn;
            r_s3_sqx      <= PW'(i_geom.mx) * PW'(i_geom.mx);
            r_s3_sqy      <= PW'(i_geom.my) * PW'(i_geom.my);
            r_s3_ww       <= PW'(i_geom.pw) * PW'(i_geom.qw);
            r_s3_hh       <= PW'(i_geom.ph) * PW'(i_geom.qh);
            r_s3_aq       <= PW'(i_geom.qw) * PW'(i_geom.qh);

            r_s4_pair     <= r_s3_pair;
            r_s4_done     <= r_s3_done;
            r_s4_done_hit <= r_s3_done_hit;
            r_s4_warn     <= r_s3_warn;
            r_s4_circ_hit <= n_s4_circ_hit;
            r_s4_cc_near  <= n_s4_cc_near;
            r_s4_pp       <= n_s4_pp;

            r_s5_pair     <= r_s4_pair;
            r_s5_done     <= r_s4_done;
            r_s5_done_hit <= r_s4_done_hit;
            r_s5_warn     <= r_s4_warn;
            r_s5_circ_hit <= r_s4_circ_hit;
            r_s5_cc_near  <= r_s4_cc_near;
            r_s5_prod     <= n_s5_prod;
        end
    end

    always_comb begin
        lhs    = {1'b0, r_s5_prod[0]} + {1'b0, r_s5_prod[1]};
        cc_hit = r_s5_cc_near && (lhs < {1'b0, r_s5_prod[2]});

        o_word.zero_size_warning = r_s5_warn;
        priority if (r_s5_done) begin
            o_word.hit = r_s5_done_hit;
        end else if (r_s5_pair == PAIR_CC) begin
            o_word.hit = cc_hit;
        end else begin
            o_word.hit = r_s5_circ_hit;
        end
    end

    assign o_valid = r_s5_v;

endmodule

// ----- design/spcol_oq.sv -----
// ----------------------------------------------------------------------------
// spcol_oq
// two-entry result queue; its registered fill level stalls the pipeline
// ----------------------------------------------------------------------------
`include "shape_pair_collision_2d_assert.svh"

module spcol_oq import spcol_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_pop,
    output t_out_word o_word
);

    localparam int DEPTH = OQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_out_word        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             pop;

    always_comb begin
        pop      = i_pop && (r_count != '0);
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_room  = r_count < CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd_ptr];

    `SPC_ASSERT_IMP(a_oq_no_overflow, i_clk, i_rst_n, i_push, r_count < CNT_W'(DEPTH))
    `SPC_ASSERT(a_oq_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))

endmodule

// ----- design/shape_pair_collision_2d.sv -----
// path: an accepted word passes stages s1 to s5, then a queue entry, before its result word is out
// throughput: one pair per cycle while the output queue has room; each stage passes one pair, no iteration
// input ready falls only while the two-entry output queue is full
// reset: synchronous active-low i_rst_n clears stage valid bits and the queue
// ----------------------------------------------------------------------------
// shape_pair_collision_2d
// pairwise 2d intersection test of points, boxes and ellipses, exact integer
// arithmetic, one result word per input word
// ----------------------------------------------------------------------------
`include "shape_pair_collision_2d_assert.svh"

module shape_pair_collision_2d import spcol_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // pair words in
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    // result words out
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // pipeline:
    //   s1  sort the shapes so the lower kind comes first, centre differences
    //   s2  absolute distances, all box tests, zero-size checks, and the
    //       operands for the round tests (corner offsets, doubled or plain distances)
    //   s3  squares of the operands, w1*w2, h1*h2 and the circle area w*h
    //   s4  point/rect against circle compare; ellipse terms split into
    //       half-width partial products
    //   s5  ellipse products assembled; the final sum and compare run into
    //       the queue entry
    // the whole pipe moves when the queue has room, so a stall freezes every
    // stage together and nothing is dropped or repeated

    logic      pipe_en;
    logic      geom_valid;
    t_geom     geom;
    logic      prod_valid;
    t_out_word prod_word;

    spcol_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_valid (geom_valid),
        .o_geom  (geom)
    );

    spcol_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (geom_valid),
        .i_geom  (geom),
        .o_valid (prod_valid),
        .o_word  (prod_word)
    );

    // queue room is a register output, so ready never depends on i_out_ready
    spcol_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pipe_en && prod_valid),
        .i_word  (prod_word),
        .o_room  (pipe_en),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_word  (o_out_word)
    );

    assign o_in_ready = pipe_en;

    // a zero-size warning always comes with a miss
    `SPC_ASSERT_IMP(a_warn_no_hit, i_clk, i_rst_n, o_out_valid, !(o_out_word.hit && o_out_word.zero_size_warning))
    // the pipe only stalls behind waiting results
    `SPC_ASSERT_IMP(a_stall_has_output, i_clk, i_rst_n, !o_in_ready, o_out_valid)

endmodule

// ----- test/tb_shape_pair_collision_2d.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shape_pair_collision_2d
// self-checking bench for the 2d shape pair collision block: a queue-fed
// driver offers pair words, a clocked monitor compares every result word
// against an exact wide-integer intersection predictor, under random idling
// on both handshakes and one long output stall
// ----------------------------------------------------------------------------
module tb_shape_pair_collision_2d import spcol_pkg::*; ();

    localparam int POS_MAX          = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int POS_MIN          = -(2 ** (COORD_WIDTH - 1));
    localparam int SIZE_MAX         = 2 ** SIZE_WIDTH - 1;
    localparam int RANDOM_PER_PHASE = 617;
    localparam int DRAIN_CYCLES     = 20;    // watch time for stray results after the drain
    localparam int STALL_CYCLES     = 300;   // long output hold-off
    localparam int STALL_AFTER      = 200;   // words accepted before the hold-off

    // one shape, unpacked from a pair word
    typedef struct {
        logic [KIND_WIDTH-1:0]         kind;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [SIZE_WIDTH-1:0]         w;
        logic [SIZE_WIDTH-1:0]         h;
    } t_shape;

    // pair word in flight together with its expected answer
    typedef struct {
        t_in_word  pair;
        t_out_word want;
    } t_contact;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_in_word  pair_q[$];       // words still to be offered
    t_contact  contact_q[$];    // accepted words awaiting their result
    t_contact  oldest;

    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;
    logic      hold_off       = 1'b0;
    int        accepted_count = 0;
    int        mismatch_count = 0;

    shape_pair_collision_2d i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // absolute centre distance along one axis, widened for the products
    function automatic logic [127:0] span(input logic signed [COORD_WIDTH-1:0] u,
                                          input logic signed [COORD_WIDTH-1:0] v);
        longint su, sv;
        su = u;
        sv = v;
        return (su >= sv) ? 128'(su - sv) : 128'(sv - su);
    endfunction

    // every halving is removed by doubling the other side, all products are
    // exact in 128 bits so nothing rounds or saturates
    function automatic t_out_word predict_contact(input t_in_word pw_in);
        t_shape       a, b, p, q;
        t_out_word    r;
        logic [127:0] dx, dy, dx2, dy2, pw, ph, qw, qh, xd, yd;
        a = '{pw_in.a_kind, pw_in.a_pos_x, pw_in.a_pos_y, pw_in.a_width, pw_in.a_height};
        b = '{pw_in.b_kind, pw_in.b_pos_x, pw_in.b_pos_y, pw_in.b_width, pw_in.b_height};
        // order the pair so the lower kind comes first
        if (a.kind <= b.kind) begin
            p = a;
            q = b;
        end else begin
            p = b;
            q = a;
        end
        r   = '0;
        dx  = span(p.x, q.x);
        dy  = span(p.y, q.y);
        dx2 = dx << 1;
        dy2 = dy << 1;
        pw  = p.w;
        ph  = p.h;
        qw  = q.w;
        qh  = q.h;
        case ({p.kind, q.kind})
            {KIND_POINT, KIND_POINT}: begin
                r.hit = (dx == 0) && (dy == 0);
            end
            {KIND_POINT, KIND_RECT}: begin
                r.hit = (dx2 <= qw) && (dy2 <= qh);
            end
            {KIND_POINT, KIND_CIRCLE}: begin
                // radius squared is w*h/4, strict inside the rim
                if (qw == 0 || qh == 0) r.zero_size_warning = 1'b1;
                else r.hit = dx2 * dx2 + dy2 * dy2 < qw * qh;
            end
            {KIND_RECT, KIND_RECT}: begin
                r.hit = (dx2 <= pw + qw) && (dy2 <= ph + qh);
            end
            {KIND_RECT, KIND_CIRCLE}: begin
                // zero-size circle gets no warning here, the test runs as is
                if (dx2 > pw + qw || dy2 > ph + qh) begin
                    r.hit = 1'b0;
                end else if (dx2 <= pw || dy2 <= ph) begin
                    r.hit = 1'b1;
                end else begin
                    xd    = dx2 - pw;
                    yd    = dy2 - ph;
                    r.hit = xd * xd + yd * yd <= qw * qh;
                end
            end
            {KIND_CIRCLE, KIND_CIRCLE}: begin
                if (pw == 0 || ph == 0 || qw == 0 || qh == 0) r.zero_size_warning = 1'b1;
                else r.hit = dx * dx * ph * qh + dy * dy * pw * qw < pw * qw * ph * qh;
            end
            default: begin
                // an unknown kind on either side: no hit and no warning
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_in_word make_pair(
        input logic [KIND_WIDTH-1:0] ak, input int ax, input int ay,
        input int aw, input int ah,
        input logic [KIND_WIDTH-1:0] bk, input int bx, input int by,
        input int bw, input int bh);
        t_in_word w;
        w.a_kind   = ak;
        w.a_pos_x  = COORD_WIDTH'(ax);
        w.a_pos_y  = COORD_WIDTH'(ay);
        w.a_width  = SIZE_WIDTH'(aw);
        w.a_height = SIZE_WIDTH'(ah);
        w.b_kind   = bk;
        w.b_pos_x  = COORD_WIDTH'(bx);
        w.b_pos_y  = COORD_WIDTH'(by);
        w.b_width  = SIZE_WIDTH'(bw);
        w.b_height = SIZE_WIDTH'(bh);
        return w;
    endfunction

    function automatic logic [KIND_WIDTH-1:0] random_kind();
        if ($urandom_range(11) == 0) return KIND_UNKNOWN;
        return KIND_WIDTH'($urandom_range(KIND_CIRCLE));
    endfunction

    // mostly small sizes, now and then zero, full range or the maximum
    function automatic logic [SIZE_WIDTH-1:0] random_size();
        int unsigned sel;
        sel = $urandom_range(15);
        if (sel == 0) return '0;
        if (sel == 1) return SIZE_WIDTH'($urandom);
        if (sel == 2) return SIZE_WIDTH'(SIZE_MAX);
        return SIZE_WIDTH'($urandom_range(1 << $urandom_range(14, 3)));
    endfunction

    function automatic longint random_pos();
        logic signed [COORD_WIDTH-1:0] v;
        case ($urandom_range(7))
            0: begin
                v = COORD_WIDTH'($urandom);
                return v;
            end
            1: return $urandom_range(1) ? POS_MAX : POS_MIN;
            default: return longint'($urandom_range(1 << 17)) - (1 << 16);
        endcase
    endfunction

    // offset around the touching distance; now and then exactly on it
    function automatic longint near_offset(input longint lim);
        longint reach;
        reach = lim + lim / 4;
        if ($urandom_range(7) == 0) return $urandom_range(1) ? lim - 2 : 2 - lim;
        return longint'($urandom_range(32'(2 * reach))) - reach;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    // second shape mostly placed close to the first so hits and misses mix
    function automatic t_in_word random_pair();
        t_in_word w;
        longint   ax, ay, bx, by, lim_x, lim_y;
        w.a_kind   = random_kind();
        w.b_kind   = random_kind();
        w.a_width  = random_size();
        w.a_height = random_size();
        w.b_width  = random_size();
        w.b_height = random_size();
        ax = random_pos();
        ay = random_pos();
        if ($urandom_range(4) == 0) begin
            bx = random_pos();
            by = random_pos();
        end else begin
            lim_x = (longint'(w.a_width) + longint'(w.b_width)) / 2 + 2;
            lim_y = (longint'(w.a_height) + longint'(w.b_height)) / 2 + 2;
            bx    = clamp_pos(ax + near_offset(lim_x));
            by    = clamp_pos(ay + near_offset(lim_y));
        end
        w.a_pos_x = COORD_WIDTH'(ax);
        w.a_pos_y = COORD_WIDTH'(ay);
        w.b_pos_x = COORD_WIDTH'(bx);
        w.b_pos_y = COORD_WIDTH'(by);
        return w;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued words, holds valid and payload until taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                contact_q.push_back('{in_word, predict_contact(in_word)});
                accepted_count++;
            end
            if (!in_valid || o_in_ready) begin
                if (pair_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_word  <= pair_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random ready, compares each result word with the oldest
    // expectation field by field
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (contact_q.size() == 0) begin
                    note_mismatch($sformatf("result word %p with nothing expected", o_out_word));
                end else begin
                    oldest = contact_q.pop_front();
                    if (o_out_word.hit !== oldest.want.hit)
                        note_mismatch($sformatf("hit expected %0b got %0b for pair %p",
                            oldest.want.hit, o_out_word.hit, oldest.pair));
                    if (o_out_word.zero_size_warning !== oldest.want.zero_size_warning)
                        note_mismatch($sformatf("warning expected %0b got %0b for pair %p",
                            oldest.want.zero_size_warning, o_out_word.zero_size_warning,
                            oldest.pair));
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long output hold-off while the sender keeps offering, so the output
    // queue fills and input ready drops
    initial begin
        wait (accepted_count >= STALL_AFTER);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (STALL_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // run time cap, far beyond the slowest correct run
    initial begin
        #400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence: reset, three idling phases, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            send_gap_pct   = (phase == 0) ? 28 : (phase == 1) ? 60 : 0;
            recv_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 28 : 0;
            if (phase == 0) begin
                // point on point, then one lsb apart
                pair_q.push_back(make_pair(KIND_POINT, 0, 0, 0, 0, KIND_POINT, 0, 0, 0, 0));
                pair_q.push_back(make_pair(KIND_POINT, 5, -3, 0, 0, KIND_POINT, 5, -2, 0, 0));
                // point on the inclusive edge of a box, then just past it
                pair_q.push_back(make_pair(KIND_POINT, 100, 0, 0, 0, KIND_RECT, 0, 0, 200, 50));
                pair_q.push_back(make_pair(KIND_POINT, 101, 0, 0, 0, KIND_RECT, 0, 0, 200, 50));
                // point on a zero-size box
                pair_q.push_back(make_pair(KIND_POINT, -7, 9, 0, 0, KIND_RECT, -7, 9, 0, 0));
                // zero-size circle against a point, both orders
                pair_q.push_back(make_pair(KIND_POINT, 0, 0, 0, 0, KIND_CIRCLE, 0, 0, 0, 100));
                pair_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 100, 0, KIND_POINT, 0, 0, 0, 0));
                // strict rim of a circle against a point
                pair_q.push_back(make_pair(KIND_POINT, 50, 0, 0, 0, KIND_CIRCLE, 0, 0, 100, 100));
                pair_q.push_back(make_pair(KIND_POINT, 49, 0, 0, 0, KIND_CIRCLE, 0, 0, 100, 100));
                // boxes touching, then one lsb apart
                pair_q.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_RECT, 100, 0, 100, 100));
                pair_q.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_RECT, 101, 0, 100, 100));
                // circle near a box corner: outside the rounded corner, then inside
                pair_q.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_CIRCLE, 80, 80, 60, 60));
                pair_q.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_CIRCLE, 80, 80, 100, 100));
                pair_q.push_back(make_pair(KIND_CIRCLE, 80, 80, 100, 100, KIND_RECT, 0, 0, 100, 100));
                // zero-size circle against a box: plain test, no warning
                pair_q.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_CIRCLE, 10, 10, 0, 0));
                pair_q.push_back(make_pair(KIND_RECT, 0, 0, 100, 100, KIND_CIRCLE, 500, 10, 0, 0));
                // circles: concentric, touching, zero size, ellipses
                pair_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 100, 100, KIND_CIRCLE, 0, 0, 100, 100));
                pair_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 100, 100, KIND_CIRCLE, 100, 0, 100, 100));
                pair_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 0, 100, KIND_CIRCLE, 0, 0, 100, 100));
                pair_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 400, 100, KIND_CIRCLE, 100, 0, 40, 10));
                // unknown kinds, including beside a zero-size circle
                pair_q.push_back(make_pair(KIND_UNKNOWN, 0, 0, 0, 0, KIND_POINT, 0, 0, 0, 0));
                pair_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 0, 0, KIND_UNKNOWN, 0, 0, 0, 0));
                // far corners and full sizes
                pair_q.push_back(make_pair(KIND_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                                           KIND_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX));
                pair_q.push_back(make_pair(KIND_CIRCLE, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX,
                                           KIND_CIRCLE, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX));
                pair_q.push_back(make_pair(KIND_CIRCLE, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX,
                                           KIND_CIRCLE, POS_MAX - 1000, POS_MAX, SIZE_MAX, 1));
                pair_q.push_back(make_pair(KIND_RECT, POS_MIN, 0, SIZE_MAX, SIZE_MAX,
                                           KIND_CIRCLE, 0, 0, SIZE_MAX, SIZE_MAX));
            end
            repeat (RANDOM_PER_PHASE) pair_q.push_back(random_pair());
            while (pair_q.size() != 0 || in_valid) @(negedge i_clk);
        end
        // let the pipeline and output queue empty, then watch for strays
        while (contact_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && contact_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
